// File: src/iolh_pkg.sv
package iolh_pkg;

	localparam int US_BUCKETS = 16;
	localparam int MS_BUCKETS = 16;
	localparam int S_BUCKETS = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int BUCKETS_PER_KIND = US_BUCKETS + MS_BUCKETS + S_BUCKETS;
	localparam int COUNTER_TOTAL = 4 * BUCKETS_PER_KIND;
	localparam int IDX_W = $clog2(COUNTER_TOTAL);
	localparam int BKT_W = 12;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] RANGE_US = 2'd0;
	localparam logic [1:0] RANGE_MS = 2'd1;
	localparam logic [1:0] RANGE_S = 2'd2;
	localparam logic [1:0] RANGE_NONE = 2'd3;

	localparam logic [1:0] REG_TIMER_MS = 2'd0;
	localparam logic [1:0] REG_US_GRAIN = 2'd1;
	localparam logic [1:0] REG_MS_GRAIN = 2'd2;
	localparam logic [1:0] REG_S_GRAIN = 2'd3;

	// Operation handed from the classifier to the counter store
	typedef struct packed {
		logic [1:0] op;
		logic counted;
		logic [1:0] hit_range;
		logic [3:0] hit_bucket;
		logic rd_ok;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
	} op_t;

	function automatic logic [IDX_W-1:0] counter_index(logic soft_sel, logic wr,
			logic [1:0] rng, logic [BKT_W-1:0] bkt);
		int base;
		base = (rng == RANGE_US) ? 0 : (rng == RANGE_MS) ? US_BUCKETS : US_BUCKETS + MS_BUCKETS;
		return IDX_W'((int'({soft_sel, wr})) * BUCKETS_PER_KIND + base + int'(bkt));
	endfunction

	function automatic logic [BKT_W-1:0] range_last(logic [1:0] rng);
		case (rng)
			RANGE_US: return BKT_W'(US_BUCKETS - 1);
			RANGE_MS: return BKT_W'(MS_BUCKETS - 1);
			default: return BKT_W'(S_BUCKETS - 1);
		endcase
	endfunction

endpackage

// File: src/iolh_divider.sv
// Restoring divider, one quotient bit per cycle.
module iolh_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [15:0] divisor,
	output logic done,
	output logic [31:0] quotient
);
	logic [5:0] cnt_q;
	logic busy_q;
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? 16'd1 : divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: src/iolh_front.sv
// Classify items: latency, range and bucket, counter addresses.
module iolh_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [31:0] start_time,
	input logic [31:0] end_time,
	input logic soft_path,
	input logic is_write,
	input logic [1:0] grain_select,
	input logic [3:0] bucket_select,
	input logic timer_in_ms,
	input logic [9:0] us_grain,
	input logic [9:0] ms_grain,
	input logic [15:0] s_grain,
	output logic op_valid,
	input logic op_ready,
	output iolh_pkg::op_t op
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCALE, ST_R1, ST_R2, ST_DIV, ST_WAIT, ST_OUT
	} state_t;

	localparam int BKT_W_L = iolh_pkg::BKT_W;
	// ceil(2^37 / 125): exact floor division by 125 for any 30-bit value
	localparam logic [30:0] RECIP_125 = 31'd1099511628;

	state_t state_q;
	logic soft_q, wr_q;
	logic [1:0] rng_q;
	logic [41:0] lat_q;
	logic [31:0] val_q;
	logic div_start_q;
	logic div_done;
	logic [31:0] quo;
	logic [15:0] div_dvs;
	logic [31:0] lat_in;
	logic [31:0] r1_div;
	logic [31:0] r2_div;
	logic [BKT_W_L-1:0] bkt;
	iolh_pkg::op_t idle_op;

	// Divide by 1000 as a shift by 3 and a reciprocal multiply by 1/125
	function automatic logic [31:0] div1000(logic [32:0] x);
		logic [60:0] prod;
		prod = {31'd0, x[32:3]} * {30'd0, RECIP_125};
		return 32'(prod >> 37);
	endfunction

	iolh_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.dividend(val_q), .divisor(div_dvs), .done(div_done), .quotient(quo)
	);

	assign div_dvs = (rng_q == iolh_pkg::RANGE_US) ? {6'd0, us_grain} :
		(rng_q == iolh_pkg::RANGE_MS) ? {6'd0, ms_grain} : s_grain;

	assign lat_in = end_time - start_time;
	assign in_ready = (state_q == ST_IDLE);
	assign op_valid = (state_q == ST_OUT);

	// Round to whole milliseconds; a millisecond timer already gives them
	assign r1_div = timer_in_ms ? val_q : div1000({1'b0, val_q} + 33'd500);
	// Round milliseconds to whole seconds
	assign r2_div = div1000({1'b0, val_q} + 33'd500);

	// Clamp quotient to the range's last bucket
	always_comb begin
		if (quo > 32'(iolh_pkg::range_last(rng_q))) bkt = iolh_pkg::range_last(rng_q);
		else bkt = BKT_W_L'(quo);
	end

	// Build the operation for an incoming beat
	always_comb begin
		idle_op = '0;
		idle_op.op = cmd;
		if (cmd == iolh_pkg::CMD_RECORD) begin
			if (!(end_time > start_time)) idle_op.op = iolh_pkg::CMD_NONE;
		end else begin
			idle_op.rd_ok = (grain_select != iolh_pkg::RANGE_NONE) &&
				({8'd0, bucket_select} <= iolh_pkg::range_last(grain_select));
			idle_op.idx_a = iolh_pkg::counter_index(soft_path, 1'b0, grain_select,
				{8'd0, bucket_select});
			idle_op.idx_b = iolh_pkg::counter_index(soft_path, 1'b1, grain_select,
				{8'd0, bucket_select});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_start_q <= 1'b0;
			op <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					soft_q <= soft_path;
					wr_q <= is_write;
					lat_q <= {10'd0, lat_in};
					val_q <= lat_in;
					op <= idle_op;
					if (cmd == iolh_pkg::CMD_RECORD && end_time > start_time)
						state_q <= ST_SCALE;
					else
						state_q <= ST_OUT;
				end
				ST_SCALE: begin
					if (timer_in_ms) lat_q <= lat_q * 42'd1000;
					state_q <= ST_R1;
				end
				ST_R1: begin
					if (lat_q < 42'd1000) begin
						rng_q <= iolh_pkg::RANGE_US;
						val_q <= lat_q[31:0];
						div_start_q <= 1'b1;
						state_q <= ST_WAIT;
					end else begin
						rng_q <= (lat_q < 42'd1000000) ? iolh_pkg::RANGE_MS : iolh_pkg::RANGE_S;
						val_q <= r1_div;
						state_q <= ST_R2;
					end
				end
				ST_R2: begin
					if (rng_q == iolh_pkg::RANGE_S) val_q <= r2_div;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_start_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (div_done) begin
					op.counted <= 1'b1;
					op.hit_range <= rng_q;
					op.hit_bucket <= bkt[3:0];
					op.idx_a <= iolh_pkg::counter_index(soft_q, wr_q, rng_q, bkt);
					state_q <= ST_OUT;
				end
				ST_OUT: if (op_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: src/iolh_back.sv
// Counter store: saturating increment, bucket read, clearing sweep.
module iolh_back (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	output logic op_ready,
	input iolh_pkg::op_t op,
	output logic out_valid,
	input logic out_ready,
	output logic [103:0] out_data
);
	localparam int IW = iolh_pkg::IDX_W;
	localparam int CW = iolh_pkg::COUNT_WIDTH;

	typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD1, B_RD2, B_WR, B_CLR, B_OUT} state_t;

	state_t state_q;
	logic [CW-1:0] mem [iolh_pkg::COUNTER_TOTAL];
	logic [CW-1:0] rdata_q;
	logic [CW-1:0] rc_q;
	logic [IW-1:0] addr;
	logic [IW-1:0] clr_q;
	iolh_pkg::op_t op_q;
	logic we;
	logic [CW-1:0] wdata;

	assign op_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_OUT);

	always_comb begin
		addr = (state_q == B_RD1) ? op_q.idx_b : op_q.idx_a;
		if (state_q == B_CLR || state_q == B_INIT) addr = clr_q;
		we = (state_q == B_WR && op_q.op == iolh_pkg::CMD_RECORD && rdata_q != '1) ||
			state_q == B_CLR || state_q == B_INIT;
		wdata = (state_q == B_CLR || state_q == B_INIT) ? '0 : rdata_q + CW'(1);
	end

	// Single port memory with registered read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			clr_q <= '0;
			out_data <= '0;
		end else begin
			unique case (state_q)
				// Zero every counter after reset
				B_INIT: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(iolh_pkg::COUNTER_TOTAL - 1)) state_q <= B_IDLE;
				end
				B_IDLE: if (op_valid) begin
					op_q <= op;
					clr_q <= '0;
					unique case (op.op)
						iolh_pkg::CMD_RECORD: state_q <= B_RD1;
						iolh_pkg::CMD_READ: state_q <= B_RD1;
						iolh_pkg::CMD_CLEAR: state_q <= B_CLR;
						default: begin
							out_data <= '0;
							state_q <= B_OUT;
						end
					endcase
				end
				B_RD1: state_q <= B_RD2;
				B_RD2: begin
					rc_q <= rdata_q;
					if (op_q.op == iolh_pkg::CMD_RECORD) begin
						state_q <= B_WR;
					end else begin
						state_q <= B_WR;
					end
				end
				B_WR: begin
					if (op_q.op == iolh_pkg::CMD_RECORD) begin
						out_data <= {97'd0, op_q.hit_bucket, op_q.hit_range, op_q.counted};
					end else if (op_q.rd_ok) begin
						out_data <= {33'(rc_q) + 33'(rdata_q), 32'(rc_q), 32'(rdata_q), 7'd0};
					end else begin
						out_data <= '0;
					end
					state_q <= B_OUT;
				end
				B_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(iolh_pkg::COUNTER_TOTAL - 1)) begin
						out_data <= '0;
						state_q <= B_OUT;
					end
				end
				B_OUT: if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// File: src/io_latency_histogram.sv
// I/O latency histogram.
// Input stream (s_axis_*): one beat per command. tdata holds, from bit 0:
// cmd, start_time, end_time, soft_path, is_write, grain_select, bucket_select.
// Output stream (m_axis_*): exactly one beat per input beat, in order. tdata
// holds, from bit 0: counted, hit_range, hit_bucket, read_total, write_total,
// all_total.
// Config channel (cfg_*): index 0 timer_in_ms, 1 us_grain, 2 ms_grain,
// 3 s_grain; write only while the block is idle.
// A counted record passes the classifier's scale and round states, the bit-serial
// grain divider (from 1 ms up after an added rounding state) and a counter read and
// write; a read fetches two counters, an ignored record or unknown command goes
// straight out, and a clear zeroes one counter a cycle.
// The classifier and the counter store each hold one operation, so a new
// beat is taken while the previous result still waits.
// After reset the store zeroes its 192 counters, one a cycle; a beat taken
// meanwhile waits in the classifier until that pass ends.
// A stalled output holds its beat; the store and then the input stall behind it.
module io_latency_histogram (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [79:0] s_axis_tdata, // cmd, start_time, end_time, soft, wr, gsel, bsel
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [103:0] m_axis_tdata, // counted, range, bucket, rd, wr, all
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic timer_q;
	logic [9:0] usg_q, msg_q;
	logic [15:0] sg_q;
	logic op_valid, op_ready;
	iolh_pkg::op_t op;

	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= 1'b1;
			usg_q <= 10'd64;
			msg_q <= 10'd64;
			sg_q <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				iolh_pkg::REG_TIMER_MS: timer_q <= cfg_data[0];
				iolh_pkg::REG_US_GRAIN: usg_q <= cfg_data[9:0];
				iolh_pkg::REG_MS_GRAIN: msg_q <= cfg_data[9:0];
				iolh_pkg::REG_S_GRAIN: sg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	iolh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tdata[1:0]), .start_time(s_axis_tdata[33:2]),
		.end_time(s_axis_tdata[65:34]), .soft_path(s_axis_tdata[66]),
		.is_write(s_axis_tdata[67]), .grain_select(s_axis_tdata[69:68]),
		.bucket_select(s_axis_tdata[73:70]),
		.timer_in_ms(timer_q), .us_grain(usg_q), .ms_grain(msg_q), .s_grain(sg_q),
		.op_valid(op_valid), .op_ready(op_ready), .op(op)
	);

	iolh_back u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_ready(op_ready), .op(op),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);
endmodule

// File: src/iolh_checker.sv
module iolh_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [103:0] m_axis_tdata
);
	// A stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped");
	// Counted record carries no counts
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[103:7] == '0)
		else $error("record beat carries counts");
	// Range code never three
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3)
		else $error("bad range");
	// An accepted input beat closes the input for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");
endmodule

bind io_latency_histogram iolh_checker u_chk (.*);
